// ===== rtl/core/ebalu_pkg.sv =====
// ebalu_pkg: shared types and constants of the 8-bit alu with flags
// operation codes, flag bit positions, request and response payload structs
// no dependencies

package ebalu_pkg;

  // operation codes, as carried in the op field of a request
  typedef enum logic [4:0] {
    OpAdd  = 5'd0,
    OpAdc  = 5'd1,
    OpSub  = 5'd2,
    OpSbc  = 5'd3,
    OpCp   = 5'd4,
    OpAnd  = 5'd5,
    OpXor  = 5'd6,
    OpOr   = 5'd7,
    OpInc  = 5'd8,
    OpDec  = 5'd9,
    OpRlc  = 5'd10,
    OpRrc  = 5'd11,
    OpRl   = 5'd12,
    OpRr   = 5'd13,
    OpSla  = 5'd14,
    OpSra  = 5'd15,
    OpSll  = 5'd16,
    OpSrl  = 5'd17,
    OpBit  = 5'd18,
    OpRes  = 5'd19,
    OpSet  = 5'd20,
    OpRlca = 5'd21,
    OpRrca = 5'd22,
    OpRla  = 5'd23,
    OpRra  = 5'd24,
    OpCpl  = 5'd25,
    OpNeg  = 5'd26,
    OpScf  = 5'd27,
    OpCcf  = 5'd28
  } op_e;

  // flag byte masks: S Z Y H X P/V N C from bit 7 down to bit 0
  localparam logic [7:0] FlagS = 8'h80;
  localparam logic [7:0] FlagZ = 8'h40;
  localparam logic [7:0] FlagY = 8'h20;
  localparam logic [7:0] FlagH = 8'h10;
  localparam logic [7:0] FlagX = 8'h08;
  localparam logic [7:0] FlagP = 8'h04;
  localparam logic [7:0] FlagN = 8'h02;
  localparam logic [7:0] FlagC = 8'h01;

  typedef struct packed {
    logic [4:0] op;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [2:0] bit_index;
  } req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags_out;
  } rsp_t;

endpackage

// ===== rtl/core/ebalu_exec.sv =====
// ebalu_exec: combinational datapath of the 8-bit alu
// computes result and new flag byte from one request and the current flags
// depends on ebalu_pkg

module ebalu_exec (
  input  ebalu_pkg::req_t req_i,
  input  logic [7:0]      flags_i,
  output ebalu_pkg::rsp_t rsp_o
);

  // S Z Y X taken from a value
  function automatic logic [7:0] szyx(input logic [7:0] v);
    logic [7:0] f;
    f = v & (ebalu_pkg::FlagS | ebalu_pkg::FlagY | ebalu_pkg::FlagX);
    if (v == 8'h00) begin
      f = f | ebalu_pkg::FlagZ;
    end
    return f;
  endfunction

  // flags of logic ops and the shift group: szyx, even parity, given h and c
  function automatic logic [7:0] logic_f(input logic [7:0] v, input logic h, input logic c);
    logic [7:0] f;
    f = szyx(v);
    if (~^v) begin
      f = f | ebalu_pkg::FlagP;
    end
    if (h) begin
      f = f | ebalu_pkg::FlagH;
    end
    if (c) begin
      f = f | ebalu_pkg::FlagC;
    end
    return f;
  endfunction

  // accumulator rotates keep S Z P/V
  function automatic logic [7:0] acc_f(input logic [7:0] v, input logic [7:0] fo,
                                       input logic c);
    return (fo & (ebalu_pkg::FlagS | ebalu_pkg::FlagZ | ebalu_pkg::FlagP))
         | (v & (ebalu_pkg::FlagY | ebalu_pkg::FlagX))
         | {7'b0, c};
  endfunction

  ebalu_pkg::op_e op;
  logic [7:0] a;
  logic [7:0] b;
  logic       cf;
  logic [7:0] bit_mask;

  // shared adder / subtractor
  logic       is_sub;
  logic [7:0] ax;
  logic [7:0] ay;
  logic       ac;
  logic [8:0] sum9;
  logic [7:0] arith_f;

  logic [7:0] inc_v;
  logic [7:0] dec_v;
  logic [7:0] res_v;
  logic [7:0] flg_v;

  assign op       = ebalu_pkg::op_e'(req_i.op);
  assign a        = req_i.operand_a;
  assign b        = req_i.operand_b;
  assign cf       = flags_i[0];
  assign bit_mask = 8'b1 << req_i.bit_index;

  always_comb begin
    is_sub = (op == ebalu_pkg::OpSub) || (op == ebalu_pkg::OpSbc) ||
             (op == ebalu_pkg::OpCp)  || (op == ebalu_pkg::OpNeg);
    ax     = (op == ebalu_pkg::OpNeg) ? 8'h00 : a;
    ay     = (op == ebalu_pkg::OpNeg) ? a : b;
    ac     = ((op == ebalu_pkg::OpAdc) || (op == ebalu_pkg::OpSbc)) ? cf : 1'b0;
    if (is_sub) begin
      sum9 = {1'b0, ax} - {1'b0, ay} - {8'b0, ac};
    end else begin
      sum9 = {1'b0, ax} + {1'b0, ay} + {8'b0, ac};
    end
    arith_f = szyx(sum9[7:0]);
    if (is_sub) begin
      arith_f = arith_f | ebalu_pkg::FlagN;
    end
    if (sum9[8]) begin
      arith_f = arith_f | ebalu_pkg::FlagC;
    end
    if ((is_sub ? (ax[7] ^ ay[7]) : ~(ax[7] ^ ay[7])) && (ax[7] ^ sum9[7])) begin
      arith_f = arith_f | ebalu_pkg::FlagP;
    end
    if (ax[4] ^ ay[4] ^ sum9[4]) begin
      arith_f = arith_f | ebalu_pkg::FlagH;
    end
  end

  assign inc_v = a + 8'd1;
  assign dec_v = a - 8'd1;

  always_comb begin
    res_v = a;
    flg_v = flags_i;
    case (op)
      ebalu_pkg::OpAdd, ebalu_pkg::OpAdc, ebalu_pkg::OpSub, ebalu_pkg::OpSbc,
      ebalu_pkg::OpCp, ebalu_pkg::OpNeg: begin
        res_v = sum9[7:0];
        flg_v = arith_f;
      end
      ebalu_pkg::OpAnd: begin
        res_v = a & b;
        flg_v = logic_f(res_v, 1'b1, 1'b0);
      end
      ebalu_pkg::OpXor: begin
        res_v = a ^ b;
        flg_v = logic_f(res_v, 1'b0, 1'b0);
      end
      ebalu_pkg::OpOr: begin
        res_v = a | b;
        flg_v = logic_f(res_v, 1'b0, 1'b0);
      end
      ebalu_pkg::OpInc: begin
        res_v = inc_v;
        flg_v = szyx(inc_v) | {7'b0, cf};
        if (inc_v == 8'h80) begin
          flg_v = flg_v | ebalu_pkg::FlagP;
        end
        if (inc_v[3:0] == 4'h0) begin
          flg_v = flg_v | ebalu_pkg::FlagH;
        end
      end
      ebalu_pkg::OpDec: begin
        res_v = dec_v;
        flg_v = szyx(dec_v) | {7'b0, cf} | ebalu_pkg::FlagN;
        if (dec_v == 8'h7f) begin
          flg_v = flg_v | ebalu_pkg::FlagP;
        end
        if (dec_v[3:0] == 4'hf) begin
          flg_v = flg_v | ebalu_pkg::FlagH;
        end
      end
      ebalu_pkg::OpRlc: begin
        res_v = {a[6:0], a[7]};
        flg_v = logic_f(res_v, 1'b0, a[7]);
      end
      ebalu_pkg::OpRrc: begin
        res_v = {a[0], a[7:1]};
        flg_v = logic_f(res_v, 1'b0, a[0]);
      end
      ebalu_pkg::OpRl: begin
        res_v = {a[6:0], cf};
        flg_v = logic_f(res_v, 1'b0, a[7]);
      end
      ebalu_pkg::OpRr: begin
        res_v = {cf, a[7:1]};
        flg_v = logic_f(res_v, 1'b0, a[0]);
      end
      ebalu_pkg::OpSla: begin
        res_v = {a[6:0], 1'b0};
        flg_v = logic_f(res_v, 1'b0, a[7]);
      end
      ebalu_pkg::OpSra: begin
        res_v = {a[7], a[7:1]};
        flg_v = logic_f(res_v, 1'b0, a[0]);
      end
      ebalu_pkg::OpSll: begin
        res_v = {a[6:0], 1'b1};
        flg_v = logic_f(res_v, 1'b0, a[7]);
      end
      ebalu_pkg::OpSrl: begin
        res_v = {1'b0, a[7:1]};
        flg_v = logic_f(res_v, 1'b0, a[0]);
      end
      ebalu_pkg::OpBit: begin
        flg_v = (flags_i & ~(ebalu_pkg::FlagZ | ebalu_pkg::FlagN)) | ebalu_pkg::FlagH;
        if ((a & bit_mask) == 8'h00) begin
          flg_v = flg_v | ebalu_pkg::FlagZ;
        end
      end
      ebalu_pkg::OpRes: begin
        res_v = a & ~bit_mask;
      end
      ebalu_pkg::OpSet: begin
        res_v = a | bit_mask;
      end
      ebalu_pkg::OpRlca: begin
        res_v = {a[6:0], a[7]};
        flg_v = acc_f(res_v, flags_i, a[7]);
      end
      ebalu_pkg::OpRrca: begin
        res_v = {a[0], a[7:1]};
        flg_v = acc_f(res_v, flags_i, a[0]);
      end
      ebalu_pkg::OpRla: begin
        res_v = {a[6:0], cf};
        flg_v = acc_f(res_v, flags_i, a[7]);
      end
      ebalu_pkg::OpRra: begin
        res_v = {cf, a[7:1]};
        flg_v = acc_f(res_v, flags_i, a[0]);
      end
      ebalu_pkg::OpCpl: begin
        res_v = ~a;
        flg_v = (flags_i & (ebalu_pkg::FlagS | ebalu_pkg::FlagZ |
                            ebalu_pkg::FlagP | ebalu_pkg::FlagC))
              | (res_v & (ebalu_pkg::FlagY | ebalu_pkg::FlagX))
              | ebalu_pkg::FlagH | ebalu_pkg::FlagN;
      end
      ebalu_pkg::OpScf: begin
        flg_v = (flags_i & ~(ebalu_pkg::FlagH | ebalu_pkg::FlagN)) | ebalu_pkg::FlagC;
      end
      ebalu_pkg::OpCcf: begin
        // half carry takes the old carry
        flg_v = (flags_i & ~(ebalu_pkg::FlagH | ebalu_pkg::FlagN | ebalu_pkg::FlagC))
              | (cf ? ebalu_pkg::FlagH : ebalu_pkg::FlagC);
      end
      default: begin
        // unused codes pass operand_a and keep the flags
        res_v = a;
        flg_v = flags_i;
      end
    endcase
  end

  assign rsp_o.result    = res_v;
  assign rsp_o.flags_out = flg_v;

endmodule

// ===== rtl/core/eight_bit_alu_with_flags.sv =====
// eight_bit_alu_with_flags: 8-bit alu with a kept flag register, top level
// input register, combinational datapath (ebalu_exec), result register
// depends on ebalu_pkg and ebalu_exec
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_ready_o   in_req_i  (op, operands, bit index)
//   out      response   out_valid_o / out_ready_i out_rsp_o (result, flags_out)
//
// a request goes through the input register, then the result register, and a stall
// on out_ready_i can hold it; one request per cycle sustained while out_ready_i
// stays high, set by the single pass through the datapath between the two registers
// the flag register is written when a request moves into the result register,
// so the next request in the input register already sees the new carry
// reset clears the valid bits and the flag register
// a stall on out_ready_i holds both stages; in_ready_o stays high while the
// input stage is empty or can drain

module eight_bit_alu_with_flags (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ebalu_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ebalu_pkg::rsp_t out_rsp_o
);

  // input stage
  logic            in_valid_q;
  logic            in_valid_d;
  ebalu_pkg::req_t in_req_q;

  // result stage
  logic            out_valid_q;
  logic            out_valid_d;
  ebalu_pkg::rsp_t out_rsp_q;

  // kept flag byte
  logic [7:0]      flag_q;
  logic [7:0]      flag_d;

  ebalu_pkg::rsp_t exec_rsp;
  logic            advance;
  logic            in_fire;

  // datapath
  ebalu_exec u_exec (
    .req_i   (in_req_q),
    .flags_i (flag_q),
    .rsp_o   (exec_rsp)
  );

  // move from input stage to result stage when the result slot is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    flag_d      = flag_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      in_valid_d  = 1'b0;
      flag_d      = exec_rsp.flags_out;
    end
    if (in_fire) begin
      in_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flag_q      <= 8'h00;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      flag_q      <= flag_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_req_q <= in_req_i;
    end
    if (advance) begin
      out_rsp_q <= exec_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== tb/alu_result_checker.sv =====
// alu_result_checker: watches both channels of the 8-bit alu, predicts each response
// from accepted requests with its own flag register copy and compares field by field
// depends on ebalu_pkg

module alu_result_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  ebalu_pkg::req_t in_req_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  ebalu_pkg::rsp_t out_rsp_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              req_count_o,
  output int              rsp_count_o
);
  import ebalu_pkg::*;

  localparam int PrintCap = 100;

  typedef struct packed {
    req_t rq;
    rsp_t rs;
  } alu_op_t;

  logic [7:0] flags_q;
  alu_op_t    awaited_q[$];
  alu_op_t    head;

  task automatic report_mismatch(string msg);
    if (fail_count_o < PrintCap) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  function automatic logic [7:0] szyx_of(logic [7:0] v);
    return (v & (FlagS | FlagY | FlagX)) | ((v == '0) ? FlagZ : '0);
  endfunction

  function automatic rsp_t add_sub(logic [7:0] x, logic [7:0] y, logic c, logic sub);
    logic [8:0] w;
    logic [7:0] z, f, ovf;
    w = sub ? ({1'b0, x} - {1'b0, y} - c) : ({1'b0, x} + {1'b0, y} + c);
    z = w[7:0];
    ovf = sub ? ((x ^ y) & (x ^ z) & FlagS) : (~(x ^ y) & (x ^ z) & FlagS);
    f = szyx_of(z) | (w[8] ? FlagC : '0) | (sub ? FlagN : '0) | ((ovf != '0) ? FlagP : '0)
        | (((x ^ y ^ z) & FlagH) != '0 ? FlagH : '0);
    return {z, f};
  endfunction

  // logic ops and the cb shift group: s z y x from value, even parity, n clear
  function automatic rsp_t logic_rsp(logic [7:0] z, logic [7:0] h, logic c);
    return {z, szyx_of(z) | ((~^z) ? FlagP : '0) | h | (c ? FlagC : '0)};
  endfunction

  // accumulator rotates keep s z p/v
  function automatic rsp_t acc_rsp(logic [7:0] z, logic c);
    return {z, (flags_q & (FlagS | FlagZ | FlagP)) | (z & (FlagY | FlagX)) | (c ? FlagC : '0)};
  endfunction

  function automatic rsp_t alu_execute(req_t rq);
    rsp_t       rs;
    logic [7:0] a, b, z, f;
    logic       cf;
    a = rq.operand_a;
    b = rq.operand_b;
    cf = |(flags_q & FlagC);
    rs = {a, flags_q};
    case (rq.op)
      OpAdd: rs = add_sub(a, b, 1'b0, 1'b0);
      OpAdc: rs = add_sub(a, b, cf, 1'b0);
      OpSub, OpCp: rs = add_sub(a, b, 1'b0, 1'b1);
      OpSbc: rs = add_sub(a, b, cf, 1'b1);
      OpAnd: rs = logic_rsp(a & b, FlagH, 1'b0);
      OpXor: rs = logic_rsp(a ^ b, '0, 1'b0);
      OpOr:  rs = logic_rsp(a | b, '0, 1'b0);
      OpInc: begin
        z = a + 8'd1;
        f = szyx_of(z) | (flags_q & FlagC) | ((z == FlagS) ? FlagP : '0)
            | ((z[3:0] == '0) ? FlagH : '0);
        rs = {z, f};
      end
      OpDec: begin
        z = a - 8'd1;
        f = szyx_of(z) | (flags_q & FlagC) | FlagN | ((z == ~FlagS) ? FlagP : '0)
            | ((z[3:0] == '1) ? FlagH : '0);
        rs = {z, f};
      end
      OpRlc: rs = logic_rsp({a[6:0], a[7]}, '0, a[7]);
      OpRrc: rs = logic_rsp({a[0], a[7:1]}, '0, a[0]);
      OpRl:  rs = logic_rsp({a[6:0], cf}, '0, a[7]);
      OpRr:  rs = logic_rsp({cf, a[7:1]}, '0, a[0]);
      OpSla: rs = logic_rsp({a[6:0], 1'b0}, '0, a[7]);
      OpSra: rs = logic_rsp({a[7], a[7:1]}, '0, a[0]);
      OpSll: rs = logic_rsp({a[6:0], 1'b1}, '0, a[7]);
      OpSrl: rs = logic_rsp({1'b0, a[7:1]}, '0, a[0]);
      OpBit: begin
        f = (flags_q & ~(FlagZ | FlagN)) | FlagH | (a[rq.bit_index] ? '0 : FlagZ);
        rs = {a, f};
      end
      OpRes: begin
        z = a;
        z[rq.bit_index] = 1'b0;
        rs = {z, flags_q};
      end
      OpSet: begin
        z = a;
        z[rq.bit_index] = 1'b1;
        rs = {z, flags_q};
      end
      OpRlca: rs = acc_rsp({a[6:0], a[7]}, a[7]);
      OpRrca: rs = acc_rsp({a[0], a[7:1]}, a[0]);
      OpRla:  rs = acc_rsp({a[6:0], cf}, a[7]);
      OpRra:  rs = acc_rsp({cf, a[7:1]}, a[0]);
      OpCpl: begin
        z = ~a;
        f = (flags_q & (FlagS | FlagZ | FlagP | FlagC)) | (z & (FlagY | FlagX)) | FlagH | FlagN;
        rs = {z, f};
      end
      OpNeg: rs = add_sub('0, a, 1'b0, 1'b1);
      OpScf: rs = {a, (flags_q & ~(FlagH | FlagN)) | FlagC};
      // h takes the carry from before the complement
      OpCcf: rs = {a, (flags_q & ~(FlagH | FlagN | FlagC)) | (cf ? FlagH : FlagC)};
      default: ;
    endcase
    flags_q = rs.flags_out;
    return rs;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q = '0;
      awaited_q.delete();
      fail_count_o = 0;
      req_count_o = 0;
      rsp_count_o = 0;
    end else begin
      // responses first: a request accepted on this edge cannot answer on it
      if (out_valid_i && out_ready_i) begin
        rsp_count_o++;
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with nothing awaited", rsp_count_o));
        end else begin
          head = awaited_q.pop_front();
          if (out_rsp_i.result !== head.rs.result) begin
            report_mismatch($sformatf("op %0d a %h b %h bit %0d: result %h, want %h",
                head.rq.op, head.rq.operand_a, head.rq.operand_b, head.rq.bit_index,
                out_rsp_i.result, head.rs.result));
          end
          if (out_rsp_i.flags_out !== head.rs.flags_out) begin
            report_mismatch($sformatf("op %0d a %h b %h bit %0d: flags %b, want %b",
                head.rq.op, head.rq.operand_a, head.rq.operand_b, head.rq.bit_index,
                out_rsp_i.flags_out, head.rs.flags_out));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        req_count_o++;
        awaited_q.push_back({in_req_i, alu_execute(in_req_i)});
      end
    end
    pending_o = awaited_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: drives requests into the 8-bit alu with flags and stalls its response side
// at random; alu_result_checker predicts and compares, this module gives the verdict
// depends on ebalu_pkg, eight_bit_alu_with_flags and alu_result_checker

module tb_top;
  import ebalu_pkg::*;

  // codes past ccf have no name in the package; the block treats them as no-ops
  localparam logic [4:0] FirstUnusedOp = 5'(OpCcf) + 5'd1;
  localparam logic [4:0] LastOpCode    = 5'h1f;
  // cycles without any handshake before the run is called hung; this is far above
  // the longest sender gap and receiver stall that pick_len can give
  localparam int IdleLimit    = 2000;
  localparam int PhaseItems   = 240;
  localparam int PhaseCount   = 4;
  localparam int ResetCycles  = 12;
  // room to spare after the last response before the verdict
  localparam int SettleCycles = 8;

  logic clk_i;
  logic rst_ni     = 1'b0;
  logic in_valid   = 1'b0;
  logic out_ready  = 1'b0;
  req_t in_req     = '0;
  logic in_ready;
  logic out_valid;
  rsp_t out_rsp;

  int          errors;
  int          pending;
  int          n_req;
  int          n_rsp;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  // while calm is set neither side idles, giving back-to-back stretches
  logic        calm        = 1'b1;
  logic [31:0] ops_sent    = '0;

  eight_bit_alu_with_flags uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  alu_result_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .fail_count_o (errors),
    .pending_o    (pending),
    .req_count_o  (n_req),
    .rsp_count_o  (n_rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // gap or stall length: mostly from the shortest of its three ranges, now and then a long one
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // operands lean on the carry, overflow and half-carry boundaries
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 12))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h7f;
      3: return 8'h80;
      4: return 8'h0f;
      5: return 8'h10;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic req_t mk_req(logic [4:0] op, logic [7:0] a, logic [7:0] b, logic [2:0] bi);
    req_t rq;
    rq.op = op;
    rq.operand_a = a;
    rq.operand_b = b;
    rq.bit_index = bi;
    return rq;
  endfunction

  // one request: optional idle gap, then valid held until the block takes it
  task automatic send_req(req_t rq);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 35) ? pick_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= rq;
    ops_sent[rq.op] = 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // response side: ready drops for random stretches, which never start while calm
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) stall_left = pick_len();
    end
  end

  // watchdog: any accepted request or response counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles, %0d responses awaited", idle_cycles, pending);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [4:0] op;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, back to back so each op sees the flags of the one before
    send_req(mk_req(OpScf,  8'h00, 8'h00, 3'd0));   // carry in for adc
    send_req(mk_req(OpAdc,  8'hff, 8'h00, 3'd0));   // wraps to zero, h and c
    send_req(mk_req(OpSbc,  8'h00, 8'hff, 3'd0));   // borrow in and out
    send_req(mk_req(OpAdd,  8'h7f, 8'h01, 3'd0));   // signed overflow
    send_req(mk_req(OpSub,  8'h80, 8'h01, 3'd0));   // signed overflow downward
    send_req(mk_req(OpCp,   8'h55, 8'haa, 3'd0));   // y and x from the difference
    send_req(mk_req(OpAnd,  8'hff, 8'hff, 3'd0));
    send_req(mk_req(OpXor,  8'hff, 8'hff, 3'd0));   // zero with even parity
    send_req(mk_req(OpOr,   8'h00, 8'h00, 3'd0));
    send_req(mk_req(OpInc,  8'h7f, 8'h00, 3'd0));   // overflow into 0x80
    send_req(mk_req(OpDec,  8'h80, 8'h00, 3'd0));   // overflow into 0x7f
    send_req(mk_req(OpInc,  8'hff, 8'h00, 3'd0));   // carry kept across wrap
    send_req(mk_req(OpDec,  8'h00, 8'h00, 3'd0));
    send_req(mk_req(OpRlc,  8'h80, 8'h00, 3'd0));
    send_req(mk_req(OpRrc,  8'h01, 8'h00, 3'd0));
    send_req(mk_req(OpRl,   8'h80, 8'h00, 3'd0));
    send_req(mk_req(OpRr,   8'h01, 8'h00, 3'd0));
    send_req(mk_req(OpSla,  8'hff, 8'h00, 3'd0));
    send_req(mk_req(OpSra,  8'h80, 8'h00, 3'd0));
    send_req(mk_req(OpSll,  8'h00, 8'h00, 3'd0));
    send_req(mk_req(OpSrl,  8'hff, 8'h00, 3'd0));
    send_req(mk_req(OpBit,  8'h7f, 8'h00, 3'd7));   // tested bit clear, only z h n move
    send_req(mk_req(OpRes,  8'hff, 8'h00, 3'd0));
    send_req(mk_req(OpSet,  8'h00, 8'h00, 3'd7));
    send_req(mk_req(OpRlca, 8'h80, 8'h00, 3'd0));   // s z p/v kept
    send_req(mk_req(OpRrca, 8'h01, 8'h00, 3'd0));
    send_req(mk_req(OpRla,  8'hff, 8'h00, 3'd0));
    send_req(mk_req(OpRra,  8'h01, 8'h00, 3'd0));
    send_req(mk_req(OpCpl,  8'h5a, 8'h00, 3'd0));
    send_req(mk_req(OpNeg,  8'h80, 8'h00, 3'd0));   // overflow, sets carry
    send_req(mk_req(OpCcf,  8'h3c, 8'h00, 3'd0));   // h from the old carry
    send_req(mk_req(LastOpCode, 8'ha5, 8'h5a, 3'd3)); // unused code acts as no-op

    // random part; the first phase runs with no idling on either side
    for (int ph = 0; ph < PhaseCount; ph++) begin
      calm = (ph == 0);
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 99) < 4) begin
          op = 5'($urandom_range(FirstUnusedOp, LastOpCode));
        end else begin
          op = 5'($urandom_range(OpAdd, OpCcf));
        end
        send_req(mk_req(op, pick_byte(), pick_byte(), 3'($urandom_range(0, 7))));
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;
    calm = 1'b1;

    // drain; a response that never comes trips the watchdog
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    $display("%0d requests over %0d of 32 op codes, %0d responses checked",
             n_req, $countones(ops_sent), n_rsp);
    $display("random idling on both sides after a back-to-back phase, %0d mismatches", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
